// ===== hdl/vps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package vps_pkg;

  localparam int GRID_REG_BITS = 7;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 32;
  localparam int GRID_MIN      = 3;

  localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_ADV_X  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_ADV_Y  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_DIFF_X = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_DIFF_Y = 3'd5;

  localparam logic [GRID_REG_BITS-1:0] GRID_WIDTH_RST  = 7'd11;
  localparam logic [GRID_REG_BITS-1:0] GRID_HEIGHT_RST = 7'd11;
  localparam logic [31:0] COEF_ADV_RST  = 32'd21474836;
  localparam logic [31:0] COEF_DIFF_RST = 32'd42949673;

  // One product per step; TX/TY produce the coefficient term for AX/AY.
  typedef enum logic [2:0] {
    STEP_FX,
    STEP_FY,
    STEP_TX,
    STEP_AX,
    STEP_TY,
    STEP_AY
  } step_t;

  typedef enum logic [1:0] {
    OSRC_WIN,
    OSRC_ROW1,
    OSRC_ROW2,
    OSRC_PRED
  } osrc_t;

  typedef struct packed {
    logic  capture;
    logic  shift;
    logic  acc_init;
    logic  mul_lo;
    logic  mul_hi;
    logic  mul_fin;
    logic  res_store;
    logic  out_load;
    logic  last;
    logic  comp_v;
    step_t step;
    osrc_t osrc;
  } dp_cmd_t;

endpackage

`default_nettype wire

// ===== hdl/vps_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface vps_in_if #(
  parameter int VELOCITY_BITS = 32
);
  logic                            valid;
  logic                            ready;
  logic signed [VELOCITY_BITS-1:0] u_in;
  logic signed [VELOCITY_BITS-1:0] v_in;
  logic                            flush;

  modport source (output valid, output u_in, output v_in, output flush, input ready);
  modport sink   (input valid, input u_in, input v_in, input flush, output ready);
endinterface

`default_nettype wire

// ===== hdl/vps_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface vps_out_if #(
  parameter int VELOCITY_BITS = 32
);
  logic                            valid;
  logic                            ready;
  logic signed [VELOCITY_BITS-1:0] u_pred;
  logic signed [VELOCITY_BITS-1:0] v_pred;
  logic                            last_point;
  logic                            saturated;

  modport source (output valid, output u_pred, output v_pred, output last_point,
                  output saturated, input ready);
  modport sink   (input valid, input u_pred, input v_pred, input last_point,
                  input saturated, output ready);
endinterface

`default_nettype wire

// ===== hdl/vps_cfg_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface vps_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [vps_pkg::CFG_IDX_BITS-1:0]  index;
  logic [vps_pkg::CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/velocity_predictor_stencil_unit.sv =====
// Latency: the result for a grid point leaves after grid_width+1 further items.
// An interior point needs 12 products on one shared multiplier; input is not
// taken while a point is in process. A result waiting in the output register
// stalls input only once the next result is ready to load.
// Reset (rst_n, synchronous): counters, state and config registers to defaults; line store and datapath kept.
`timescale 1ns / 1ps
`default_nettype none

module velocity_predictor_stencil_unit #(
  parameter int MAX_WIDTH     = 64,
  parameter int MAX_HEIGHT    = 64,
  parameter int VELOCITY_BITS = 32,
  parameter int COEF_BITS     = 32
) (
  input wire logic clk,
  input wire logic rst_n,
  vps_in_if.sink   in_ch,
  vps_out_if.source out_ch,
  vps_cfg_if.sink  cfg_ch
);

  localparam int CW   = $clog2(MAX_WIDTH + 1);
  localparam int RW   = $clog2(MAX_HEIGHT + 1);
  localparam int AIW  = $clog2(MAX_WIDTH);
  localparam int GB   = vps_pkg::GRID_REG_BITS;
  localparam int CMPW = ((CW > RW) ? CW : RW) > GB ? ((CW > RW) ? CW : RW) + 1 : GB + 1;

  logic [GB-1:0]        grid_w_r, grid_h_r;
  logic [COEF_BITS-1:0] coef_ax_r, coef_ay_r, coef_dx_r, coef_dy_r;
  logic                 cfg_accept, grid_reset;
  logic [CMPW-1:0]      gw_ext, gh_ext;
  logic [CW-1:0]        w_eff;
  logic [RW-1:0]        h_eff;

  vps_pkg::dp_cmd_t          cmd;
  logic                      mem_we, mem_rd;
  logic [AIW-1:0]            mem_addr;
  logic [2*VELOCITY_BITS-1:0] row1_rdata, row2_rdata, row1_wdata, row2_wdata;

  assign cfg_ch.ready = 1'b1;
  assign cfg_accept   = cfg_ch.valid && cfg_ch.ready;
  assign grid_reset   = cfg_accept && (cfg_ch.index == vps_pkg::CFG_GRID_WIDTH ||
                                       cfg_ch.index == vps_pkg::CFG_GRID_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_w_r  <= vps_pkg::GRID_WIDTH_RST;
      grid_h_r  <= vps_pkg::GRID_HEIGHT_RST;
      coef_ax_r <= COEF_BITS'(vps_pkg::COEF_ADV_RST);
      coef_ay_r <= COEF_BITS'(vps_pkg::COEF_ADV_RST);
      coef_dx_r <= COEF_BITS'(vps_pkg::COEF_DIFF_RST);
      coef_dy_r <= COEF_BITS'(vps_pkg::COEF_DIFF_RST);
    end else if (cfg_accept) begin
      case (cfg_ch.index)
        vps_pkg::CFG_GRID_WIDTH:  grid_w_r  <= cfg_ch.data[GB-1:0];
        vps_pkg::CFG_GRID_HEIGHT: grid_h_r  <= cfg_ch.data[GB-1:0];
        vps_pkg::CFG_COEF_ADV_X:  coef_ax_r <= cfg_ch.data[COEF_BITS-1:0];
        vps_pkg::CFG_COEF_ADV_Y:  coef_ay_r <= cfg_ch.data[COEF_BITS-1:0];
        vps_pkg::CFG_COEF_DIFF_X: coef_dx_r <= cfg_ch.data[COEF_BITS-1:0];
        vps_pkg::CFG_COEF_DIFF_Y: coef_dy_r <= cfg_ch.data[COEF_BITS-1:0];
        default: ;
      endcase
    end
  end

  // clamp grid size into 3..MAX
  always_comb begin
    gw_ext = CMPW'(grid_w_r);
    gh_ext = CMPW'(grid_h_r);
    if (gw_ext < CMPW'(vps_pkg::GRID_MIN)) begin
      w_eff = CW'(vps_pkg::GRID_MIN);
    end else if (gw_ext > CMPW'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(gw_ext);
    end
    if (gh_ext < CMPW'(vps_pkg::GRID_MIN)) begin
      h_eff = RW'(vps_pkg::GRID_MIN);
    end else if (gh_ext > CMPW'(MAX_HEIGHT)) begin
      h_eff = RW'(MAX_HEIGHT);
    end else begin
      h_eff = RW'(gh_ext);
    end
  end

  vps_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_flush    (in_ch.flush),
    .in_ready    (in_ch.ready),
    .out_valid_r (out_ch.valid),
    .out_ready   (out_ch.ready),
    .grid_reset  (grid_reset),
    .w_eff       (w_eff),
    .h_eff       (h_eff),
    .mem_we      (mem_we),
    .mem_rd      (mem_rd),
    .mem_addr    (mem_addr),
    .cmd         (cmd)
  );

  vps_ram #(
    .DEPTH (MAX_WIDTH),
    .WIDTH (2 * VELOCITY_BITS),
    .AW    (AIW)
  ) u_row1 (
    .clk     (clk),
    .we      (mem_we),
    .rd      (mem_rd),
    .addr    (mem_addr),
    .wdata   (row1_wdata),
    .rdata_r (row1_rdata)
  );

  vps_ram #(
    .DEPTH (MAX_WIDTH),
    .WIDTH (2 * VELOCITY_BITS),
    .AW    (AIW)
  ) u_row2 (
    .clk     (clk),
    .we      (mem_we),
    .rd      (mem_rd),
    .addr    (mem_addr),
    .wdata   (row2_wdata),
    .rdata_r (row2_rdata)
  );

  vps_dp #(
    .VELOCITY_BITS (VELOCITY_BITS),
    .COEF_BITS     (COEF_BITS)
  ) u_dp (
    .clk          (clk),
    .cmd          (cmd),
    .u_in         (in_ch.u_in),
    .v_in         (in_ch.v_in),
    .coef_adv_x   (coef_ax_r),
    .coef_adv_y   (coef_ay_r),
    .coef_diff_x  (coef_dx_r),
    .coef_diff_y  (coef_dy_r),
    .row1_rdata   (row1_rdata),
    .row2_rdata   (row2_rdata),
    .row1_wdata   (row1_wdata),
    .row2_wdata   (row2_wdata),
    .u_pred_r     (out_ch.u_pred),
    .v_pred_r     (out_ch.v_pred),
    .last_point_r (out_ch.last_point),
    .saturated_r  (out_ch.saturated)
  );

endmodule

`default_nettype wire

// ===== hdl/vps_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vps_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64,
  parameter int AW    = 6
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic             rd,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (rd) begin
      rdata_r <= mem[addr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/vps_mulf.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Sign-magnitude multiply in two partial products, then floor shift and clip.
module vps_mulf #(
  parameter int VELOCITY_BITS = 32,
  parameter int COEF_BITS     = 32
) (
  input  wire logic                              clk,
  input  wire logic                              lo,
  input  wire logic                              hi,
  input  wire logic [VELOCITY_BITS+8:0]          a_mag,
  input  wire logic [((COEF_BITS > VELOCITY_BITS) ? COEF_BITS : VELOCITY_BITS)-1:0] b_mag,
  input  wire logic                              neg,
  input  wire logic                              sel_vel,
  output logic signed [VELOCITY_BITS+8:0]        res,
  output logic                                   sat
);

  localparam int AMW  = VELOCITY_BITS + 9;
  localparam int BMW  = (COEF_BITS > VELOCITY_BITS) ? COEF_BITS : VELOCITY_BITS;
  localparam int PW   = AMW + BMW;
  localparam int LOW  = AMW / 2;
  localparam int HIW  = AMW - LOW;
  localparam int VF   = VELOCITY_BITS - 8;
  localparam int LIMW = VELOCITY_BITS + 8;
  localparam logic [PW-1:0]   MASK_C  = (PW'(1) << COEF_BITS) - PW'(1);
  localparam logic [PW-1:0]   MASK_VF = (PW'(1) << VF) - PW'(1);
  localparam logic [LIMW-1:0] LIM     = '1;

  logic [PW-1:0]      prod_r;
  logic [LOW+BMW-1:0] p_lo;
  logic [HIW+BMW-1:0] p_hi;
  logic [PW-1:0]      q;
  logic               rem;
  logic               top;
  logic [LIMW:0]      m;
  logic               clip;
  logic [LIMW-1:0]    mag;

  assign p_lo = a_mag[LOW-1:0] * b_mag;
  assign p_hi = a_mag[AMW-1:LOW] * b_mag;

  always_ff @(posedge clk) begin
    if (lo) begin
      prod_r <= PW'(p_lo);
    end else if (hi) begin
      prod_r <= prod_r + (PW'(p_hi) << LOW);
    end
  end

  always_comb begin
    q    = sel_vel ? (prod_r >> VF) : (prod_r >> COEF_BITS);
    rem  = sel_vel ? (|(prod_r & MASK_VF)) : (|(prod_r & MASK_C));
    top  = |q[PW-1:LIMW];
    m    = {1'b0, q[LIMW-1:0]} + (LIMW+1)'(neg & rem);
    clip = top | m[LIMW];
    mag  = clip ? LIM : m[LIMW-1:0];
    res  = neg ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
    sat  = clip;
  end

endmodule

`default_nettype wire

// ===== hdl/vps_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vps_dp #(
  parameter int VELOCITY_BITS = 32,
  parameter int COEF_BITS     = 32
) (
  input  wire logic                              clk,
  input  wire vps_pkg::dp_cmd_t                  cmd,
  input  wire logic signed [VELOCITY_BITS-1:0]   u_in,
  input  wire logic signed [VELOCITY_BITS-1:0]   v_in,
  input  wire logic [COEF_BITS-1:0]              coef_adv_x,
  input  wire logic [COEF_BITS-1:0]              coef_adv_y,
  input  wire logic [COEF_BITS-1:0]              coef_diff_x,
  input  wire logic [COEF_BITS-1:0]              coef_diff_y,
  input  wire logic [2*VELOCITY_BITS-1:0]        row1_rdata,
  input  wire logic [2*VELOCITY_BITS-1:0]        row2_rdata,
  output logic      [2*VELOCITY_BITS-1:0]        row1_wdata,
  output logic      [2*VELOCITY_BITS-1:0]        row2_wdata,
  output logic signed [VELOCITY_BITS-1:0]        u_pred_r,
  output logic signed [VELOCITY_BITS-1:0]        v_pred_r,
  output logic                                   last_point_r,
  output logic                                   saturated_r
);

  localparam int V   = VELOCITY_BITS;
  localparam int SAW = V + 9;
  localparam int BMW = (COEF_BITS > V) ? COEF_BITS : V;
  localparam int BSW = BMW + 1;
  localparam int SW  = V + 12;
  localparam logic signed [SW-1:0] VMAX = signed'({{(SW-V+1){1'b0}}, {(V-1){1'b1}}});
  localparam logic signed [SW-1:0] VMIN = -VMAX - SW'(1);

  logic signed [V-1:0]   u_cap_r, v_cap_r;
  logic signed [V-1:0]   win_u_r [9];
  logic signed [V-1:0]   win_v_r [9];
  logic signed [V-1:0]   nu [3];
  logic signed [V-1:0]   nv [3];
  logic signed [V-1:0]   qn [9];
  logic signed [SAW-1:0] c, ddx, ddy, lx, ly;
  logic signed [SAW-1:0] t_r;
  logic signed [SAW-1:0] a;
  logic signed [BSW-1:0] b;
  logic                  sel_vel;
  logic [SAW-1:0]        a_mag;
  logic [BMW-1:0]        b_mag;
  logic                  neg;
  logic signed [SAW-1:0] mres;
  logic                  msat;
  logic signed [SW-1:0]  acc_r;
  logic signed [V-1:0]   ru_r, rv_r;
  logic signed [V-1:0]   sres;
  logic                  ssat;
  logic                  sat_r;

  assign nu[0] = row1_rdata[V-1:0];
  assign nv[0] = row1_rdata[2*V-1:V];
  assign nu[1] = row2_rdata[V-1:0];
  assign nv[1] = row2_rdata[2*V-1:V];
  assign nu[2] = u_cap_r;
  assign nv[2] = v_cap_r;

  assign row1_wdata = row2_rdata;
  assign row2_wdata = {v_cap_r, u_cap_r};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      u_cap_r <= u_in;
      v_cap_r <= v_in;
    end
    if (cmd.shift) begin
      for (int r = 0; r < 3; r++) begin
        win_u_r[r*3]     <= win_u_r[r*3+1];
        win_u_r[r*3+1]   <= win_u_r[r*3+2];
        win_u_r[r*3+2]   <= nu[r];
        win_v_r[r*3]     <= win_v_r[r*3+1];
        win_v_r[r*3+1]   <= win_v_r[r*3+2];
        win_v_r[r*3+2]   <= nv[r];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      qn[i] = cmd.comp_v ? win_v_r[i] : win_u_r[i];
    end
    c   = SAW'(qn[4]);
    ddx = SAW'(qn[5]) - SAW'(qn[3]);
    ddy = SAW'(qn[7]) - SAW'(qn[1]);
    lx  = SAW'(qn[5]) + SAW'(qn[3]) - (c <<< 1);
    ly  = SAW'(qn[7]) + SAW'(qn[1]) - (c <<< 1);
  end

  always_comb begin
    a       = lx;
    b       = signed'(BSW'(coef_diff_x));
    sel_vel = 1'b0;
    case (cmd.step)
      vps_pkg::STEP_FX: begin
        a = lx;
        b = signed'(BSW'(coef_diff_x));
      end
      vps_pkg::STEP_FY: begin
        a = ly;
        b = signed'(BSW'(coef_diff_y));
      end
      vps_pkg::STEP_TX: begin
        a = ddx;
        b = signed'(BSW'(coef_adv_x));
      end
      vps_pkg::STEP_AX: begin
        a       = t_r;
        b       = BSW'(win_u_r[4]);
        sel_vel = 1'b1;
      end
      vps_pkg::STEP_TY: begin
        a = ddy;
        b = signed'(BSW'(coef_adv_y));
      end
      vps_pkg::STEP_AY: begin
        a       = t_r;
        b       = BSW'(win_v_r[4]);
        sel_vel = 1'b1;
      end
      default: begin
        a = lx;
      end
    endcase
    a_mag = a[SAW-1] ? SAW'(-a) : SAW'(a);
    b_mag = b[BSW-1] ? BMW'(-b) : BMW'(b);
    neg   = a[SAW-1] ^ b[BSW-1];
  end

  vps_mulf #(
    .VELOCITY_BITS (VELOCITY_BITS),
    .COEF_BITS     (COEF_BITS)
  ) u_mulf (
    .clk     (clk),
    .lo      (cmd.mul_lo),
    .hi      (cmd.mul_hi),
    .a_mag   (a_mag),
    .b_mag   (b_mag),
    .neg     (neg),
    .sel_vel (sel_vel),
    .res     (mres),
    .sat     (msat)
  );

  always_comb begin
    ssat = 1'b0;
    sres = acc_r[V-1:0];
    if (acc_r > VMAX) begin
      sres = VMAX[V-1:0];
      ssat = 1'b1;
    end else if (acc_r < VMIN) begin
      sres = VMIN[V-1:0];
      ssat = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_init) begin
      acc_r <= SW'(c);
      if (!cmd.comp_v) begin
        sat_r <= 1'b0;
      end
    end else if (cmd.mul_fin) begin
      sat_r <= sat_r | msat;
      case (cmd.step)
        vps_pkg::STEP_FX, vps_pkg::STEP_FY: acc_r <= acc_r + SW'(mres);
        vps_pkg::STEP_AX, vps_pkg::STEP_AY: acc_r <= acc_r - SW'(mres);
        default:                            t_r   <= mres;
      endcase
    end else if (cmd.res_store) begin
      sat_r <= sat_r | ssat;
      if (cmd.comp_v) begin
        rv_r <= sres;
      end else begin
        ru_r <= sres;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      last_point_r <= cmd.last;
      case (cmd.osrc)
        vps_pkg::OSRC_WIN: begin
          u_pred_r    <= win_u_r[4];
          v_pred_r    <= win_v_r[4];
          saturated_r <= 1'b0;
        end
        vps_pkg::OSRC_ROW1: begin
          u_pred_r    <= nu[0];
          v_pred_r    <= nv[0];
          saturated_r <= 1'b0;
        end
        vps_pkg::OSRC_ROW2: begin
          u_pred_r    <= nu[1];
          v_pred_r    <= nv[1];
          saturated_r <= 1'b0;
        end
        default: begin
          u_pred_r    <= ru_r;
          v_pred_r    <= rv_r;
          saturated_r <= sat_r;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/vps_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vps_ctrl #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  input  wire logic                              in_flush,
  output logic                                   in_ready,
  output logic                                   out_valid_r,
  input  wire logic                              out_ready,
  input  wire logic                              grid_reset,
  input  wire logic [$clog2(MAX_WIDTH+1)-1:0]    w_eff,
  input  wire logic [$clog2(MAX_HEIGHT+1)-1:0]   h_eff,
  output logic                                   mem_we,
  output logic                                   mem_rd,
  output logic [$clog2(MAX_WIDTH)-1:0]           mem_addr,
  output vps_pkg::dp_cmd_t                       cmd
);

  localparam int CW  = $clog2(MAX_WIDTH + 1);
  localparam int RW  = $clog2(MAX_HEIGHT + 1);
  localparam int AIW = $clog2(MAX_WIDTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_INIT,
    S_LO,
    S_HI,
    S_FIN,
    S_STORE,
    S_OUT
  } state_t;

  state_t               state_r, state_nxt;
  logic [AIW-1:0]       col_r, col_nxt;
  logic [RW-1:0]        row_r, row_nxt;
  logic [AIW-1:0]       ec_r, ec_nxt;
  logic [RW-1:0]        er_r, er_nxt;
  vps_pkg::step_t       step_r, step_nxt;
  vps_pkg::osrc_t       osrc_r, osrc_nxt;
  logic                 comp_r, comp_nxt;
  logic                 out_valid_nxt;

  logic accept, grid_open, data_item, drain_item;
  logic primed, boundary, last, er_last_row, can_load;

  always_comb begin
    state_nxt     = state_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    ec_nxt        = ec_r;
    er_nxt        = er_r;
    step_nxt      = step_r;
    osrc_nxt      = osrc_r;
    comp_nxt      = comp_r;
    out_valid_nxt = out_valid_r;

    in_ready    = (state_r == S_IDLE);
    accept      = in_valid && in_ready;
    grid_open   = (row_r < h_eff);
    data_item   = accept && !in_flush && grid_open;
    drain_item  = accept && !grid_open;
    er_last_row = (er_r >= h_eff - RW'(1));
    primed      = (row_r >= RW'(2)) || ((row_r == RW'(1)) && (col_r != '0));
    boundary    = (er_r == '0) || er_last_row || (ec_r == '0) ||
                  (CW'(ec_r) == w_eff - CW'(1));
    last        = er_last_row && (CW'(ec_r) == w_eff - CW'(1));
    can_load    = !out_valid_r || out_ready;

    mem_rd   = data_item || drain_item;
    mem_we   = 1'b0;
    mem_addr = (state_r == S_IDLE && !grid_open) ? ec_r : col_r;

    cmd           = '0;
    cmd.capture   = accept;
    cmd.step      = step_r;
    cmd.comp_v    = comp_r;
    cmd.osrc      = osrc_r;
    cmd.last      = last;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (data_item) begin
          state_nxt = S_SHIFT;
        end else if (drain_item) begin
          osrc_nxt  = er_last_row ? vps_pkg::OSRC_ROW2 : vps_pkg::OSRC_ROW1;
          state_nxt = S_OUT;
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        mem_we    = 1'b1;
        if (CW'(col_r) + CW'(1) >= w_eff) begin
          col_nxt = '0;
          row_nxt = row_r + RW'(1);
        end else begin
          col_nxt = col_r + AIW'(1);
        end
        if (!primed) begin
          state_nxt = S_IDLE;
        end else if (boundary) begin
          osrc_nxt  = vps_pkg::OSRC_WIN;
          state_nxt = S_OUT;
        end else begin
          comp_nxt  = 1'b0;
          state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        cmd.acc_init = 1'b1;
        step_nxt     = vps_pkg::STEP_FX;
        state_nxt    = S_LO;
      end
      S_LO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = S_HI;
      end
      S_HI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        cmd.mul_fin = 1'b1;
        state_nxt   = S_LO;
        case (step_r)
          vps_pkg::STEP_FX: step_nxt = vps_pkg::STEP_FY;
          vps_pkg::STEP_FY: step_nxt = vps_pkg::STEP_TX;
          vps_pkg::STEP_TX: step_nxt = vps_pkg::STEP_AX;
          vps_pkg::STEP_AX: step_nxt = vps_pkg::STEP_TY;
          vps_pkg::STEP_TY: step_nxt = vps_pkg::STEP_AY;
          default:          state_nxt = S_STORE;
        endcase
      end
      S_STORE: begin
        cmd.res_store = 1'b1;
        if (!comp_r) begin
          comp_nxt  = 1'b1;
          state_nxt = S_INIT;
        end else begin
          osrc_nxt  = vps_pkg::OSRC_PRED;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (can_load) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (last) begin
            col_nxt = '0;
            row_nxt = '0;
            ec_nxt  = '0;
            er_nxt  = '0;
          end else if (CW'(ec_r) == w_eff - CW'(1)) begin
            ec_nxt = '0;
            er_nxt = er_r + RW'(1);
          end else begin
            ec_nxt = ec_r + AIW'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // grid size rewritten: abandon the grid in progress
    if (grid_reset) begin
      col_nxt = '0;
      row_nxt = '0;
      ec_nxt  = '0;
      er_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      col_r       <= '0;
      row_r       <= '0;
      ec_r        <= '0;
      er_r        <= '0;
      step_r      <= vps_pkg::STEP_FX;
      osrc_r      <= vps_pkg::OSRC_WIN;
      comp_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      ec_r        <= ec_nxt;
      er_r        <= er_nxt;
      step_r      <= step_nxt;
      osrc_r      <= osrc_nxt;
      comp_r      <= comp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== tb/vps_stencil_checker.sv =====
`timescale 1ns / 1ps

module vps_stencil_checker (
  input  logic  clk,
  input  logic  rst_n,
  vps_in_if     in_ch,
  vps_out_if    out_ch,
  vps_cfg_if    cfg_ch,
  output int    mismatches,
  output int    pending
);

  localparam int     ROW_MAX  = 64;
  localparam longint PROD_LIM = (longint'(1) << 40) - 1;
  localparam longint VEL_HI   = (longint'(1) << 31) - 1;
  localparam longint VEL_LO   = -(longint'(1) << 31);

  typedef struct {
    logic [31:0] u_pred;
    logic [31:0] v_pred;
    logic        last_point;
    logic        saturated;
  } point_result_t;

  point_result_t result_q[$];

  logic [6:0] width_reg, height_reg;
  longint     adv_x, adv_y, diff_x, diff_y;
  longint     rows_u[2*ROW_MAX];
  longint     rows_v[2*ROW_MAX];
  longint     win_u[9];
  longint     win_v[9];
  int         col_cnt, row_cnt, done_cnt;

  initial begin
    mismatches = 0;
    pending = 0;
    for (int k = 0; k < 2*ROW_MAX; k++) begin
      rows_u[k] = 0;
      rows_v[k] = 0;
    end
  end

  function automatic int clamp_dim(logic [6:0] raw);
    if (raw < 3) return 3;
    if (raw > 64) return 64;
    return int'(raw);
  endfunction

  // floor(a*b / 2^s), clipped to the product range
  function automatic longint scaled_product(longint a, longint b, int s, inout bit sat);
    logic signed [127:0] prod;
    logic signed [127:0] q;
    prod = 128'(a) * 128'(b);
    q = prod >>> s;
    if (q > PROD_LIM) begin
      sat = 1'b1;
      return PROD_LIM;
    end
    if (q < -PROD_LIM) begin
      sat = 1'b1;
      return -PROD_LIM;
    end
    return longint'(q);
  endfunction

  function automatic longint advect_diffuse(bit use_v, longint uc, longint vc, inout bit sat);
    longint q[9];
    longint c, ax, ay, fx, fy, r;
    for (int k = 0; k < 9; k++) q[k] = use_v ? win_v[k] : win_u[k];
    c  = q[4];
    ax = scaled_product(scaled_product(q[5] - q[3], adv_x, 32, sat), uc, 24, sat);
    ay = scaled_product(scaled_product(q[7] - q[1], adv_y, 32, sat), vc, 24, sat);
    fx = scaled_product(q[5] + q[3] - 2 * c, diff_x, 32, sat);
    fy = scaled_product(q[7] + q[1] - 2 * c, diff_y, 32, sat);
    r  = c + fx + fy - ax - ay;
    if (r > VEL_HI) begin
      r = VEL_HI;
      sat = 1'b1;
    end
    if (r < VEL_LO) begin
      r = VEL_LO;
      sat = 1'b1;
    end
    return r;
  endfunction

  task automatic accept_point(longint u, longint v, bit fl);
    int w, h, total, got, e, er, ec, ci;
    longint nu[3], nv[3];
    longint ru, rv;
    bit sat;
    point_result_t res;
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    total = w * h;
    got = row_cnt * w + col_cnt;
    e = done_cnt;
    sat = 1'b0;
    if (!fl && got < total) begin
      ci = col_cnt % ROW_MAX;
      nu[0] = rows_u[ci]; nu[1] = rows_u[ROW_MAX + ci]; nu[2] = u;
      nv[0] = rows_v[ci]; nv[1] = rows_v[ROW_MAX + ci]; nv[2] = v;
      for (int r = 0; r < 3; r++) begin
        win_u[r*3] = win_u[r*3+1]; win_u[r*3+1] = win_u[r*3+2]; win_u[r*3+2] = nu[r];
        win_v[r*3] = win_v[r*3+1]; win_v[r*3+1] = win_v[r*3+2]; win_v[r*3+2] = nv[r];
      end
      rows_u[ci] = nu[1]; rows_u[ROW_MAX + ci] = nu[2];
      rows_v[ci] = nv[1]; rows_v[ROW_MAX + ci] = nv[2];
      col_cnt++;
      if (col_cnt >= w) begin
        col_cnt = 0;
        row_cnt++;
      end
      got++;
      if (got < w + 2 || e >= total) return;
      er = e / w;
      ec = e % w;
      if (er == 0 || er >= h - 1 || ec == 0 || ec == w - 1) begin
        ru = win_u[4];
        rv = win_v[4];
      end else begin
        ru = advect_diffuse(1'b0, win_u[4], win_v[4], sat);
        rv = advect_diffuse(1'b1, win_u[4], win_v[4], sat);
      end
    end else begin
      if (got < total || e >= total) return;
      er = e / w;
      ec = (e % w) % ROW_MAX;
      if (er >= h - 1) begin
        ru = rows_u[ROW_MAX + ec];
        rv = rows_v[ROW_MAX + ec];
      end else begin
        ru = rows_u[ec];
        rv = rows_v[ec];
      end
    end
    e++;
    res.u_pred = ru[31:0];
    res.v_pred = rv[31:0];
    res.last_point = (e == total);
    res.saturated = sat;
    result_q.insert(result_q.size(), res);
    if (e >= total) begin
      col_cnt = 0; row_cnt = 0; done_cnt = 0;
    end else begin
      done_cnt = e;
    end
  endtask

  always @(posedge clk) begin
    point_result_t want;
    if (!rst_n) begin
      width_reg = vps_pkg::GRID_WIDTH_RST;
      height_reg = vps_pkg::GRID_HEIGHT_RST;
      adv_x = vps_pkg::COEF_ADV_RST; adv_y = vps_pkg::COEF_ADV_RST;
      diff_x = vps_pkg::COEF_DIFF_RST; diff_y = vps_pkg::COEF_DIFF_RST;
      for (int k = 0; k < 9; k++) begin
        win_u[k] = 0;
        win_v[k] = 0;
      end
      col_cnt = 0; row_cnt = 0; done_cnt = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected transfer u=%h v=%h", $time, out_ch.u_pred, out_ch.v_pred);
          mismatches++;
        end else begin
          want = result_q.pop_front();
          if (out_ch.u_pred !== want.u_pred || out_ch.v_pred !== want.v_pred ||
              out_ch.last_point !== want.last_point || out_ch.saturated !== want.saturated) begin
            $display("%0t: expected u=%h v=%h last=%b sat=%b, actual u=%h v=%h last=%b sat=%b",
                     $time, want.u_pred, want.v_pred, want.last_point, want.saturated,
                     out_ch.u_pred, out_ch.v_pred, out_ch.last_point, out_ch.saturated);
            mismatches++;
          end
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          vps_pkg::CFG_GRID_WIDTH: begin
            width_reg = cfg_ch.data[6:0];
            col_cnt = 0; row_cnt = 0; done_cnt = 0;
          end
          vps_pkg::CFG_GRID_HEIGHT: begin
            height_reg = cfg_ch.data[6:0];
            col_cnt = 0; row_cnt = 0; done_cnt = 0;
          end
          vps_pkg::CFG_COEF_ADV_X:  adv_x  = longint'(cfg_ch.data);
          vps_pkg::CFG_COEF_ADV_Y:  adv_y  = longint'(cfg_ch.data);
          vps_pkg::CFG_COEF_DIFF_X: diff_x = longint'(cfg_ch.data);
          vps_pkg::CFG_COEF_DIFF_Y: diff_y = longint'(cfg_ch.data);
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        accept_point(longint'($signed(in_ch.u_in)), longint'($signed(in_ch.v_in)), in_ch.flush);
    end
    pending = result_q.size();
  end

endmodule

// ===== tb/velocity_predictor_stencil_unit_test.sv =====
`timescale 1ns / 1ps

module velocity_predictor_stencil_unit_test;

  logic clk;
  logic rst_n;
  int   mismatches;
  int   pending;
  int   items;
  bit   quiet;
  bit   paused_once;

  vps_in_if  in_ch ();
  vps_out_if out_ch ();
  vps_cfg_if cfg_ch ();

  velocity_predictor_stencil_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  vps_stencil_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

  // result-side backpressure
  initial begin
    int n;
    out_ch.ready = 1'b0;
    forever begin
      if (quiet) begin
        @(negedge clk) out_ch.ready <= 1'b1;
      end else begin
        n = $urandom_range(1, 30);
        repeat (n) @(negedge clk) out_ch.ready <= 1'b1;
        if ($urandom_range(0, 1)) begin
          n = $urandom_range(1, 18);
          repeat (n) @(negedge clk) out_ch.ready <= 1'b0;
        end
      end
    end
  end

  task automatic send_point(logic [31:0] u, logic [31:0] v, logic fl);
    int n;
    n = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 18) : 0;
    repeat (n) @(negedge clk) in_ch.valid <= 1'b0;
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.u_in  <= u;
    in_ch.v_in  <= v;
    in_ch.flush <= fl;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // hold off until every expected transfer has arrived
  task automatic drain_wait();
    @(negedge clk) in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(logic [vps_pkg::CFG_IDX_BITS-1:0] idx, logic [31:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk) cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_velocity();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'h7fff_ffff;
      2: return 32'h8000_0000;
      default: return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hffff_ffff;
      2: return $urandom;
      default: return $urandom_range(0, 32'h1000_0000);
    endcase
  endfunction

  function automatic int eff_dim(int raw);
    return raw < 3 ? 3 : (raw > 64 ? 64 : raw);
  endfunction

  task automatic run_grid(int w, int h);
    int total, pause_at;
    total = w * h;
    pause_at = (!paused_once || $urandom_range(0, 3) == 0) ? $urandom_range(w + 2, total) : -1;
    for (int i = 0; i < total; i++) begin
      // a flush inside the grid is ignored
      if ($urandom_range(0, 15) == 0) send_point($urandom, $urandom, 1'b1);
      send_point(rand_velocity(), rand_velocity(), 1'b0);
      items++;
      if (i == pause_at) begin
        drain_wait();
        paused_once = 1'b1;
      end
    end
    // data during the drain acts as a flush
    for (int i = 0; i <= w; i++) begin
      send_point($urandom, $urandom, $urandom_range(0, 5) != 0);
      items++;
    end
    if ($urandom_range(0, 3) == 0) send_point($urandom, $urandom, 1'b1);
  endtask

  task automatic directed_grid(logic [31:0] centre);
    send_point(32'h7fff_ffff, 32'h8000_0000, 1'b0);
    send_point(32'h8000_0000, 32'h7fff_ffff, 1'b0);
    send_point(32'h0000_0000, 32'hffff_ffff, 1'b0);
    send_point(32'h8000_0000, 32'h7fff_ffff, 1'b0);
    send_point(32'h0100_0000, 32'h0000_0001, 1'b1);
    send_point(centre, ~centre, 1'b0);
    send_point(32'h7fff_ffff, 32'h8000_0000, 1'b0);
    send_point(32'hff00_0000, 32'h0080_0000, 1'b0);
    send_point(32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
    send_point(32'h8000_0000, 32'h8000_0000, 1'b0);
    send_point(32'h0, 32'h0, 1'b1);
    send_point(32'h1234_5678, 32'h8765_4321, 1'b0);
    send_point(32'h0, 32'h0, 1'b1);
    send_point(32'h0, 32'h0, 1'b1);
    items += 14;
  endtask

  initial begin
    int wr, hr, w, h, n;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.u_in = '0;
    in_ch.v_in = '0;
    in_ch.flush = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = vps_pkg::CFG_GRID_WIDTH;
    cfg_ch.data = '0;
    items = 0;
    quiet = 1'b0;
    paused_once = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // smallest grid, reset coefficients, then saturating coefficients
    write_reg(vps_pkg::CFG_GRID_WIDTH, 32'd3);
    write_reg(vps_pkg::CFG_GRID_HEIGHT, 32'd3);
    send_point(32'h0, 32'h0, 1'b1);
    directed_grid(32'h0000_0000);
    drain_wait();
    write_reg(vps_pkg::CFG_COEF_ADV_X, 32'hffff_ffff);
    write_reg(vps_pkg::CFG_COEF_ADV_Y, 32'hffff_ffff);
    write_reg(vps_pkg::CFG_COEF_DIFF_X, 32'hffff_ffff);
    write_reg(vps_pkg::CFG_COEF_DIFF_Y, 32'hffff_ffff);
    directed_grid(32'h7fff_ffff);

    while (items < 650) begin
      drain_wait();
      if (items > 550) quiet = 1'b1;
      if ($urandom_range(0, 4) == 0) begin
        // abandon a grid part way
        n = $urandom_range(1, eff_dim(5));
        repeat (n) send_point(rand_velocity(), rand_velocity(), 1'b0);
        drain_wait();
      end
      case ($urandom_range(0, 9))
        0: wr = $urandom_range(0, 2);
        1: wr = 64;
        2: wr = $urandom_range(65, 127);
        3: wr = 3;
        default: wr = $urandom_range(3, 9);
      endcase
      w = eff_dim(wr);
      case ($urandom_range(0, 7))
        0: hr = $urandom_range(0, 2);
        1: hr = (w <= 4) ? 127 : 3;
        2: hr = (w <= 4) ? 64 : 4;
        default: hr = (w >= 16) ? $urandom_range(3, 4) : $urandom_range(3, 8);
      endcase
      h = eff_dim(hr);
      write_reg(vps_pkg::CFG_GRID_WIDTH, wr);
      write_reg(vps_pkg::CFG_GRID_HEIGHT, hr);
      write_reg(vps_pkg::CFG_COEF_ADV_X, rand_coef());
      write_reg(vps_pkg::CFG_COEF_ADV_Y, rand_coef());
      write_reg(vps_pkg::CFG_COEF_DIFF_X, rand_coef());
      write_reg(vps_pkg::CFG_COEF_DIFF_Y, rand_coef());
      repeat ($urandom_range(1, 2)) run_grid(w, h);
    end

    quiet = 1'b1;
    @(negedge clk) in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
